### src/bsc_pkg.sv
// Package for the bright spot centroid unit: widths, constants, codes and types.
// Used by every module of the block; it has no dependencies.
package bsc_pkg;

  // Field and state widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned WIDTH_W = 13;
  localparam int unsigned COUNT_W = 25;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned GRAY_W  = 22;
  localparam int unsigned STEP_W  = $clog2(SUM_W + 1);

  // Largest raster dimension, 2**POS_W
  localparam logic [WIDTH_W-1:0] MAX_DIM = WIDTH_W'(4096);

  // Q14 luma weights and rounding offset
  localparam logic [GRAY_W-1:0] W_BLUE   = GRAY_W'(1868);
  localparam logic [GRAY_W-1:0] W_GREEN  = GRAY_W'(9617);
  localparam logic [GRAY_W-1:0] W_RED    = GRAY_W'(4899);
  localparam logic [GRAY_W-1:0] GRAY_RND = GRAY_W'(8192);
  localparam int unsigned       GRAY_SH  = 14;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = WIDTH_W;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THRESHOLD = 1'b1;
  localparam logic [WIDTH_W-1:0]   FRAME_WIDTH_RST      = WIDTH_W'(640);
  localparam logic [PIX_W-1:0]     THRESHOLD_RST        = PIX_W'(180);

  // Per-frame totals handed from the front to the divider
  typedef struct packed {
    logic [SUM_W-1:0]   col_sum;
    logic [SUM_W-1:0]   row_sum;
    logic [COUNT_W-1:0] count;
  } frame_sums_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic almost_full;
    logic empty;
  } queue_status_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIVIDE,
    BS_OUTPUT
  } back_state_e;

endpackage

### src/bsc_front.sv
// Front end: configuration registers, gray conversion, raster position and moment sums.
// Depends on bsc_pkg; pushes one frame_sums_t per frame into bsc_queue.
module bsc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bsc_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bsc_pkg::PIX_W-1:0]     blue_i,
  input  logic [bsc_pkg::PIX_W-1:0]     green_i,
  input  logic [bsc_pkg::PIX_W-1:0]     red_i,
  input  logic                          first_pixel_i,
  input  logic                          last_pixel_i,
  input  bsc_pkg::queue_status_t        q_status_i,
  output logic                          push_o,
  output bsc_pkg::frame_sums_t          push_data_o
);

  logic [bsc_pkg::WIDTH_W-1:0] frame_width_q;
  logic [bsc_pkg::PIX_W-1:0]   threshold_q;

  logic [bsc_pkg::POS_W-1:0]   col_q, col_d, col_cur;
  logic [bsc_pkg::POS_W-1:0]   row_q, row_d, row_cur;
  logic [bsc_pkg::WIDTH_W-1:0] width_eff;
  logic [bsc_pkg::WIDTH_W-1:0] col_inc, row_inc;

  logic [bsc_pkg::GRAY_W-1:0]  gray_sum;
  logic [bsc_pkg::PIX_W-1:0]   gray;
  logic                        accept;

  logic                        s1_valid_q, s1_bright_q, s1_first_q, s1_last_q;
  logic [bsc_pkg::POS_W-1:0]   s1_col_q, s1_row_q;

  logic [bsc_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  logic [bsc_pkg::SUM_W-1:0]   csum_q, csum_d, rsum_q, rsum_d;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= bsc_pkg::FRAME_WIDTH_RST;
      threshold_q   <= bsc_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bsc_pkg::REG_FRAME_WIDTH:      frame_width_q <= cfg_data_i;
        bsc_pkg::REG_BRIGHT_THRESHOLD: threshold_q   <= cfg_data_i[bsc_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off pixels while a pending frame result could find the queue full
  assign in_stall_o = q_status_i.full | (q_status_i.almost_full & s1_valid_q & s1_last_q);
  assign accept     = in_valid_i & ~in_stall_o;

  // Gray level, Q14 weights with rounding
  assign gray_sum = bsc_pkg::W_BLUE  * bsc_pkg::GRAY_W'(blue_i)
                  + bsc_pkg::W_GREEN * bsc_pkg::GRAY_W'(green_i)
                  + bsc_pkg::W_RED   * bsc_pkg::GRAY_W'(red_i)
                  + bsc_pkg::GRAY_RND;
  assign gray = gray_sum[bsc_pkg::GRAY_SH +: bsc_pkg::PIX_W];

  // Raster position: zero width acts as one, oversize clamps to the max
  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = bsc_pkg::WIDTH_W'(1);
    end else if (frame_width_q > bsc_pkg::MAX_DIM) begin
      width_eff = bsc_pkg::MAX_DIM;
    end else begin
      width_eff = frame_width_q;
    end
    col_cur = first_pixel_i ? '0 : col_q;
    row_cur = first_pixel_i ? '0 : row_q;
    col_inc = {1'b0, col_cur} + bsc_pkg::WIDTH_W'(1);
    row_inc = {1'b0, row_cur} + bsc_pkg::WIDTH_W'(1);
    if (col_inc >= width_eff) begin
      col_d = '0;
      row_d = (row_inc >= bsc_pkg::MAX_DIM) ? '0 : row_inc[bsc_pkg::POS_W-1:0];
    end else begin
      col_d = col_inc[bsc_pkg::POS_W-1:0];
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Classification stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bright_q <= (gray > threshold_q);
      s1_first_q  <= first_pixel_i;
      s1_last_q   <= last_pixel_i;
      s1_col_q    <= col_cur;
      s1_row_q    <= row_cur;
    end
  end

  // Moment accumulation; first pixel restarts the sums
  always_comb begin
    cnt_d  = s1_first_q ? '0 : cnt_q;
    csum_d = s1_first_q ? '0 : csum_q;
    rsum_d = s1_first_q ? '0 : rsum_q;
    if (s1_bright_q) begin
      cnt_d  = cnt_d + bsc_pkg::COUNT_W'(1);
      csum_d = csum_d + bsc_pkg::SUM_W'(s1_col_q);
      rsum_d = rsum_d + bsc_pkg::SUM_W'(s1_row_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      csum_q <= '0;
      rsum_q <= '0;
    end else if (s1_valid_q) begin
      cnt_q  <= cnt_d;
      csum_q <= csum_d;
      rsum_q <= rsum_d;
    end
  end

  // End of frame: hand the totals to the queue
  assign push_o              = s1_valid_q & s1_last_q;
  assign push_data_o.col_sum = csum_d;
  assign push_data_o.row_sum = rsum_d;
  assign push_data_o.count   = cnt_d;

endmodule

### src/bsc_queue.sv
// Short queue of per-frame totals between the front end and the divider.
// Depends on bsc_pkg for frame_sums_t and queue_status_t.
module bsc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  bsc_pkg::frame_sums_t   push_data_i,
  input  logic                   pop_i,
  output bsc_pkg::frame_sums_t   pop_data_o,
  output bsc_pkg::queue_status_t status_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bsc_pkg::frame_sums_t entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fill_q;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - CNT_W'(1);
      end
    end
  end

  assign pop_data_o           = entries_q[rd_ptr_q];
  assign status_o.full        = (fill_q == CNT_W'(DEPTH));
  assign status_o.almost_full = (fill_q >= CNT_W'(DEPTH - 1));
  assign status_o.empty       = (fill_q == '0);

endmodule

### src/bsc_back.sv
// Back end: bit-serial divider for both centroid quotients and the result register.
// Depends on bsc_pkg; pops frame totals from bsc_queue.
module bsc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bsc_pkg::queue_status_t      q_status_i,
  input  bsc_pkg::frame_sums_t        pop_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bsc_pkg::POS_W-1:0]   centroid_x_o,
  output logic [bsc_pkg::POS_W-1:0]   centroid_y_o,
  output logic                        light_found_o
);

  bsc_pkg::back_state_e state_q, state_d;

  logic [bsc_pkg::SUM_W-1:0]   dvd_x_q, dvd_y_q;
  logic [bsc_pkg::COUNT_W-1:0] rem_x_q, rem_y_q, rem_x_d, rem_y_d;
  logic [bsc_pkg::COUNT_W-1:0] div_q;
  logic [bsc_pkg::POS_W-1:0]   quo_x_q, quo_y_q;
  logic [bsc_pkg::STEP_W-1:0]  step_q;
  logic                        found_q;
  logic [bsc_pkg::COUNT_W:0]   sh_x, sh_y, sub_x, sub_y;
  logic                        ge_x, ge_y;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsc_pkg::BS_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = (pop_data_i.count == '0) ? bsc_pkg::BS_OUTPUT : bsc_pkg::BS_DIVIDE;
        end
      end
      bsc_pkg::BS_DIVIDE: begin
        if (step_q == bsc_pkg::STEP_W'(1)) begin
          state_d = bsc_pkg::BS_OUTPUT;
        end
      end
      bsc_pkg::BS_OUTPUT: begin
        if (!out_stall_i) begin
          state_d = bsc_pkg::BS_IDLE;
        end
      end
      default: state_d = bsc_pkg::BS_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      bsc_pkg::BS_IDLE:   pop_o       = ~q_status_i.empty;
      bsc_pkg::BS_DIVIDE: ;
      bsc_pkg::BS_OUTPUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsc_pkg::BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // One restoring-division step per cycle, both sums share the divisor
  always_comb begin
    sh_x    = {rem_x_q, dvd_x_q[bsc_pkg::SUM_W-1]};
    sh_y    = {rem_y_q, dvd_y_q[bsc_pkg::SUM_W-1]};
    ge_x    = (sh_x >= {1'b0, div_q});
    ge_y    = (sh_y >= {1'b0, div_q});
    sub_x   = sh_x - {1'b0, div_q};
    sub_y   = sh_y - {1'b0, div_q};
    rem_x_d = ge_x ? sub_x[bsc_pkg::COUNT_W-1:0] : sh_x[bsc_pkg::COUNT_W-1:0];
    rem_y_d = ge_y ? sub_y[bsc_pkg::COUNT_W-1:0] : sh_y[bsc_pkg::COUNT_W-1:0];
  end

  // Datapath; quotients keep only their low bits
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dvd_x_q <= pop_data_i.col_sum;
      dvd_y_q <= pop_data_i.row_sum;
      div_q   <= pop_data_i.count;
      rem_x_q <= '0;
      rem_y_q <= '0;
      quo_x_q <= '0;
      quo_y_q <= '0;
      found_q <= (pop_data_i.count != '0);
      step_q  <= bsc_pkg::STEP_W'(bsc_pkg::SUM_W);
    end else if (state_q == bsc_pkg::BS_DIVIDE) begin
      dvd_x_q <= {dvd_x_q[bsc_pkg::SUM_W-2:0], 1'b0};
      dvd_y_q <= {dvd_y_q[bsc_pkg::SUM_W-2:0], 1'b0};
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      quo_x_q <= {quo_x_q[bsc_pkg::POS_W-2:0], ge_x};
      quo_y_q <= {quo_y_q[bsc_pkg::POS_W-2:0], ge_y};
      step_q  <= step_q - bsc_pkg::STEP_W'(1);
    end
  end

  assign centroid_x_o  = quo_x_q;
  assign centroid_y_o  = quo_y_q;
  assign light_found_o = found_q;

endmodule

### src/bright_spot_centroid_unit.sv
// Top level of the bright spot centroid unit.
// Instantiates bsc_front, bsc_queue and bsc_back; uses bsc_pkg.
//
// Usage
//   Pixels arrive in raster order on the input channel (in_valid_i / in_stall_o),
//   one transaction per pixel: blue, green, red and the first/last frame marks.
//   One result per frame leaves on the output channel (out_valid_o / out_stall_i)
//   after the pixel flagged last_pixel_i.
//   frame_width and bright_threshold are written through cfg_we_i / cfg_index_i /
//   cfg_data_i while the block is idle.
// Timing
//   Pixels are taken one per clock while in_stall_o is low. The front classifies a
//   pixel into a register and adds it to the sums in the next. With the divider
//   free, a frame's totals pass the queue to the one-bit-per-cycle divider, which
//   walks the 36 bits of the sums; a frame with no bright pixel skips the division.
//   QUEUE_DEPTH frame results may wait before the divider; the input stalls when
//   the queue is full, or nearly full with a frame end about to be pushed.
// Reset and stall
//   Reset clears position, sums and queue, returns the divider to idle, and loads
//   width 640 and threshold 180. While out_stall_i is high the result holds
//   steady and further frames collect in the queue.
module bright_spot_centroid_unit #(
  parameter int unsigned QUEUE_DEPTH = 2  // 2 to 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bsc_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bsc_pkg::PIX_W-1:0]     blue_i,
  input  logic [bsc_pkg::PIX_W-1:0]     green_i,
  input  logic [bsc_pkg::PIX_W-1:0]     red_i,
  input  logic                          first_pixel_i,
  input  logic                          last_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bsc_pkg::POS_W-1:0]     centroid_x_o,
  output logic [bsc_pkg::POS_W-1:0]     centroid_y_o,
  output logic                          light_found_o
);

  bsc_pkg::queue_status_t q_status;
  bsc_pkg::frame_sums_t   push_data, pop_data;
  logic                   push, pop;

  bsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .first_pixel_i (first_pixel_i),
    .last_pixel_i  (last_pixel_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  bsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  bsc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .centroid_x_o  (centroid_x_o),
    .centroid_y_o  (centroid_y_o),
    .light_found_o (light_found_o)
  );

endmodule

### src/bsc_checker.sv
// Port-level checks for the bright spot centroid unit, bound to the top level.
// Depends on bsc_pkg for field widths.
module bsc_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  logic [bsc_pkg::POS_W-1:0] centroid_x_o,
  input  logic [bsc_pkg::POS_W-1:0] centroid_y_o,
  input  logic                      light_found_o
);

  // A stalled result stays offered
  a_valid_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload
  a_payload_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(centroid_x_o) && $stable(centroid_y_o) && $stable(light_found_o))
    else $error("result payload changed while stalled");

  // A frame without bright pixels reports the origin
  a_empty_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !light_found_o |-> centroid_x_o == '0 && centroid_y_o == '0)
    else $error("empty frame gave non-zero centroid");

  // Results leave one at a time: the divider returns to idle to fetch the next frame
  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("back-to-back results from the divider");

endmodule

bind bright_spot_centroid_unit bsc_checker u_bsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .centroid_x_o  (centroid_x_o),
  .centroid_y_o  (centroid_y_o),
  .light_found_o (light_found_o)
);
